/* hw/rtl/alprng_pkg.sv */
// Shared constants and types for the additive lagged-feedback draw block.
package alprng_pkg;

  localparam int LONG_LAG   = 31;
  localparam int SHORT_LAG  = 3;
  localparam int LAST_INDEX = 1000;
  localparam int IDX_W      = 10;
  localparam int FEED_START = LONG_LAG + SHORT_LAG;

  localparam logic [14:0] LCG_MULT = 15'd16807;
  localparam logic [30:0] LCG_MOD  = 31'h7FFF_FFFF;

  typedef enum logic [1:0] {
    LAG_LOAD,
    LAG_COPY,
    LAG_SUM
  } lag_mode_e;

  typedef struct packed {
    logic        start;
    logic        neg;
    logic [31:0] mag;
  } lcg_req_t;

  typedef struct packed {
    logic      push;
    lag_mode_e mode;
  } lag_ctl_t;

endpackage

/* hw/rtl/additive_lagged_prng_draw.sv */
// Top level: sequencer around the reduce unit and the lag line, output register.
//
//  channel  | dir | tdata bits           | beat
//  s_axis   | in  | [31:0] seed (signed) | one seed per draw
//  m_axis   | out | [30:0] draw, [31] 0  | one draw per seed
//
// A draw runs from the seed beat to a valid result: 30 seeding words, each through the
// two-stage reduce unit, then 969 lag words (3 copies, 966 sums) at one per cycle through
// the single adder, and a final load of the output register. s_axis_tready_o is low for
// the whole draw; a result waiting on m_axis holds only the final load, and the next
// seed is taken once it is in the register. Reset clears the sequencer and output
// register; the lag line needs no clearing.
module additive_lagged_prng_draw (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] seed
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o    // [30:0] draw, [31] zero
);
  import alprng_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LCG_ISSUE,
    ST_LCG_WAIT,
    ST_FEED,
    ST_DONE
  } state_e;

  state_e           state_q;
  logic [IDX_W-1:0] idx_q;
  logic [31:0]      mag_q;
  logic             neg_q;
  logic             out_valid_q;
  logic [30:0]      out_draw_q;

  lcg_req_t         lcg_req;
  logic             lcg_valid;
  logic [30:0]      lcg_word;
  lag_ctl_t         lag_ctl;
  logic [31:0]      load_word;
  logic [31:0]      newest;
  logic             in_beat;
  logic             out_free;

  assign in_beat  = s_axis_tvalid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || m_axis_tready_i;

  assign lcg_req.start = (state_q == ST_LCG_ISSUE);
  assign lcg_req.neg   = neg_q;
  assign lcg_req.mag   = mag_q;

  alprng_lcg u_lcg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (lcg_req),
    .valid_o (lcg_valid),
    .word_o  (lcg_word)
  );

  always_comb begin
    lag_ctl.push = 1'b0;
    lag_ctl.mode = LAG_LOAD;
    load_word    = {1'b0, lcg_word};
    unique case (state_q)
      ST_IDLE: begin
        lag_ctl.push = in_beat;
        load_word    = s_axis_tdata_i;
      end
      ST_LCG_WAIT: lag_ctl.push = lcg_valid;
      ST_FEED: begin
        lag_ctl.push = 1'b1;
        lag_ctl.mode = (idx_q < IDX_W'(FEED_START)) ? LAG_COPY : LAG_SUM;
      end
      default: lag_ctl.push = 1'b0;
    endcase
  end

  alprng_lag u_lag (
    .clk_i       (clk_i),
    .ctl_i       (lag_ctl),
    .load_word_i (load_word),
    .newest_o    (newest)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      out_draw_q  <= '0;
    end else begin
      if (out_valid_q && m_axis_tready_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_beat) begin
            idx_q   <= IDX_W'(1);
            state_q <= ST_LCG_ISSUE;
          end
        end
        ST_LCG_ISSUE: state_q <= ST_LCG_WAIT;
        ST_LCG_WAIT: begin
          if (lcg_valid) begin
            idx_q   <= idx_q + IDX_W'(1);
            state_q <= (idx_q == IDX_W'(LONG_LAG - 1)) ? ST_FEED : ST_LCG_ISSUE;
          end
        end
        ST_FEED: begin
          idx_q <= idx_q + IDX_W'(1);
          if (idx_q == IDX_W'(LAST_INDEX - 1)) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_draw_q  <= newest[31:1];
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // magnitude and sign of the word fed to the reduce unit
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      neg_q <= s_axis_tdata_i[31];
      mag_q <= s_axis_tdata_i[31] ? (~s_axis_tdata_i + 32'd1) : s_axis_tdata_i;
    end else if ((state_q == ST_LCG_WAIT) && lcg_valid) begin
      neg_q <= 1'b0;
      mag_q <= {1'b0, lcg_word};
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_draw_q};

endmodule

/* hw/rtl/alprng_lcg.sv */
// Multiply and mod 2^31-1 reduce unit for the seeding words, two register stages.
module alprng_lcg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  alprng_pkg::lcg_req_t req_i,
  output logic                 valid_o,
  output logic [30:0]          word_o
);
  import alprng_pkg::*;

  logic        v1_q, v2_q;
  logic        neg1_q, neg2_q;
  logic [46:0] prod_q, prod_d;
  logic [30:0] red_q, red_d;
  logic [31:0] fold;

  assign prod_d = {32'd0, LCG_MULT} * {15'd0, req_i.mag};

  // 2^31 == 1 mod M: fold high bits onto low bits, one conditional subtract
  assign fold  = {16'd0, prod_q[46:31]} + {1'b0, prod_q[30:0]};
  assign red_d = (fold >= {1'b0, LCG_MOD}) ? 31'(fold - {1'b0, LCG_MOD}) : fold[30:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= req_i.start;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    neg1_q <= req_i.neg;
    red_q  <= red_d;
    neg2_q <= neg1_q;
  end

  // truncating remainder of a negative product, raised by the modulus
  always_comb begin
    if (neg2_q && (red_q != 31'd0)) begin
      word_o = LCG_MOD - red_q;
    end else if (neg2_q) begin
      word_o = 31'd0;
    end else begin
      word_o = red_q;
    end
  end

  assign valid_o = v2_q;

endmodule

/* hw/rtl/alprng_lag.sv */
// Lag shift line of the last 31 words with the shared feedback adder.
module alprng_lag (
  input  logic                 clk_i,
  input  alprng_pkg::lag_ctl_t ctl_i,
  input  logic [31:0]          load_word_i,
  output logic [31:0]          newest_o
);
  import alprng_pkg::*;

  logic [31:0] sh_q [LONG_LAG];
  logic [31:0] new_word;

  always_comb begin
    unique case (ctl_i.mode)
      LAG_LOAD: new_word = load_word_i;
      LAG_COPY: new_word = sh_q[LONG_LAG-1];
      LAG_SUM:  new_word = sh_q[LONG_LAG-1] + sh_q[SHORT_LAG-1];
      default:  new_word = load_word_i;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      sh_q[0] <= new_word;
      for (int k = 1; k < LONG_LAG; k++) begin
        sh_q[k] <= sh_q[k-1];
      end
    end
  end

  assign newest_o = sh_q[0];

endmodule

/* hw/rtl/alprng_chk.sv */
// Port-level checker for the draw block, bound to the top level.
module alprng_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o
);

  a_busy_after_seed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("ready high right after a seed beat");

  a_no_early_draw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !$rose(m_axis_tvalid_o))
    else $error("draw appeared right after a seed beat");

  a_draw_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> s_axis_tready_o)
    else $error("not idle when a draw is presented");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
    else $error("stalled draw beat changed");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !m_axis_tdata_o[31])
    else $error("draw pad bit set");

endmodule

bind additive_lagged_prng_draw alprng_chk u_alprng_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

/* test/additive_lagged_prng_draw_tb.sv */
// Testbench for additive_lagged_prng_draw: drives seeds and checks each draw against a local predictor.
`timescale 1ns / 100ps

module additive_lagged_prng_draw_tb;

  localparam int     SEED_COUNT  = 600;
  localparam int     CALM_AFTER  = SEED_COUNT - 40;
  localparam int     QUIET_LIMIT = 6000;
  localparam int     DRAIN_WAIT  = 1100;
  localparam longint MULT_L      = 64'sd16807;
  localparam longint MOD_L       = 64'sd2147483647;

  typedef struct {
    logic [31:0] seed;
    logic        drain;
  } seed_item_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i;   // [31:0] seed
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [31:0] m_axis_tdata_o;   // [30:0] draw, [31] zero

  seed_item_t  seed_queue[$];
  logic [30:0] draw_expect[int];
  int          seeds_sent;
  int          draws_seen;
  int          mismatches;
  int          gap_left;
  int          stall_left;
  int          quiet_cycles;

  additive_lagged_prng_draw DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  function automatic logic [30:0] lagged_draw(logic [31:0] seed);
    logic [31:0] ring[alprng_pkg::LONG_LAG];
    longint      word;
    longint      rem;
    int          i;
    word = longint'($signed(seed));
    ring[0] = seed;
    for (i = 1; i < alprng_pkg::LONG_LAG; i++) begin
      rem = (MULT_L * word) % MOD_L;
      if (rem < 0) rem += MOD_L;
      word = rem;
      ring[i] = rem[31:0];
    end
    for (i = alprng_pkg::FEED_START; i < alprng_pkg::LAST_INDEX; i++) begin
      ring[i % alprng_pkg::LONG_LAG] = ring[i % alprng_pkg::LONG_LAG]
                                     + ring[(i - alprng_pkg::SHORT_LAG) % alprng_pkg::LONG_LAG];
    end
    return ring[(alprng_pkg::LAST_INDEX - 1) % alprng_pkg::LONG_LAG][31:1];
  endfunction

  function automatic seed_item_t mk_seed(logic [31:0] seed, logic drain);
    seed_item_t item;
    item.seed  = seed;
    item.drain = drain;
    return item;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // seed driver
  always @(posedge clk_i or negedge rst_ni) begin
    logic accepted;
    int   sent_now;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= '0;
      gap_left        <= 0;
      seeds_sent      <= 0;
    end else begin
      accepted = s_axis_tvalid_i && s_axis_tready_o;
      sent_now = seeds_sent + (accepted ? 1 : 0);
      if (accepted) begin
        draw_expect[seeds_sent] = lagged_draw(s_axis_tdata_i);
        seeds_sent <= sent_now;
      end
      if (s_axis_tvalid_i && !accepted) begin
        s_axis_tvalid_i <= 1'b1;
      end else if (accepted && sent_now < CALM_AFTER && $urandom_range(0, 2) == 0) begin
        s_axis_tvalid_i <= 1'b0;
        gap_left        <= $urandom_range(0, 2);
      end else if (gap_left > 0) begin
        s_axis_tvalid_i <= 1'b0;
        gap_left        <= gap_left - 1;
      end else if (seed_queue.size() > 0 &&
                   (!seed_queue[0].drain || sent_now == draws_seen)) begin
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i  <= seed_queue[0].seed;
        void'(seed_queue.pop_front());
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // draw monitor
  always @(posedge clk_i or negedge rst_ni) begin
    logic [30:0] want;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      stall_left      <= 0;
      draws_seen      <= 0;
      mismatches      = 0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (draws_seen >= seeds_sent) begin
          mismatches++;
          $display("%0t: unexpected draw beat: expected none, actual %h",
                   $time, m_axis_tdata_o);
        end else begin
          want = draw_expect[draws_seen];
          if (m_axis_tdata_o[30:0] !== want) begin
            mismatches++;
            $display("%0t: draw %0d: expected %h, actual %h",
                     $time, draws_seen, want, m_axis_tdata_o[30:0]);
          end
          if (m_axis_tdata_o[31] !== 1'b0) begin
            mismatches++;
            $display("%0t: draw %0d pad bit: expected 0, actual %b",
                     $time, draws_seen, m_axis_tdata_o[31]);
          end
        end
        draws_seen <= draws_seen + 1;
      end
      if (stall_left > 0) begin
        m_axis_tready_i <= 1'b0;
        stall_left      <= stall_left - 1;
      end else if (draws_seen < CALM_AFTER && $urandom_range(0, 3) == 0) begin
        m_axis_tready_i <= 1'b0;
        stall_left      <= $urandom_range(0, 2);
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // watchdog: no beat on either side for too long
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else if ((s_axis_tvalid_i && s_axis_tready_o) ||
                 (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("additive_lagged_prng_draw verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [31:0] pick;
    int          n;
    rst_ni = 1'b0;

    // corners: zero, sign extremes, modulus multiples, bit patterns
    seed_queue.push_back(mk_seed(32'h0000_0000, 1'b0));
    seed_queue.push_back(mk_seed(32'h0000_0001, 1'b0));
    seed_queue.push_back(mk_seed(32'hFFFF_FFFF, 1'b0));
    seed_queue.push_back(mk_seed(32'h7FFF_FFFF, 1'b0));
    seed_queue.push_back(mk_seed(32'h8000_0000, 1'b0));
    seed_queue.push_back(mk_seed(32'h8000_0001, 1'b0));
    seed_queue.push_back(mk_seed(32'h7FFF_FFFE, 1'b1));
    seed_queue.push_back(mk_seed(32'hFFFF_FFFE, 1'b0));
    seed_queue.push_back(mk_seed(32'h5555_5555, 1'b0));
    seed_queue.push_back(mk_seed(32'hAAAA_AAAA, 1'b0));
    seed_queue.push_back(mk_seed(32'h0000_41A7, 1'b0));
    seed_queue.push_back(mk_seed(32'hFFFF_BE59, 1'b0));
    seed_queue.push_back(mk_seed(32'h0001_F31D, 1'b0));
    seed_queue.push_back(mk_seed(32'h0000_0000, 1'b0));
    seed_queue.push_back(mk_seed(32'hC000_0000, 1'b0));
    seed_queue.push_back(mk_seed(32'h4000_0000, 1'b0));

    n = SEED_COUNT - seed_queue.size();
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(0, 9))
        0:       pick = $urandom_range(0, 200000);
        1:       pick = -$urandom_range(1, 200000);
        default: pick = $urandom;
      endcase
      seed_queue.push_back(mk_seed(pick, k == n / 2));
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (seeds_sent != SEED_COUNT || draws_seen != seeds_sent) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (mismatches == 0 && draws_seen == seeds_sent) begin
      $display("additive_lagged_prng_draw verification clean");
    end else begin
      $display("additive_lagged_prng_draw verification failed");
    end
    $finish;
  end

endmodule
